/* src/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define AST_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define AST_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/dcm_pkg.sv */
package dcm_pkg;

  // Internal width of the position counter and seek target
  localparam int POSITION_BITS = 16;
  // Fixed width of position fields on the channels
  localparam int FIELD_POS_BITS = 16;
  // Width used to sign or zero extend between the two
  localparam int POS_WIDE_BITS = 32;

  localparam int CMD_BITS = 4;
  localparam int CFG_INDEX_BITS = 4;

  // Command codes
  typedef enum logic [CMD_BITS-1:0] {
    OP_SENSOR    = 4'd0,
    OP_ID_QUERY  = 4'd1,
    OP_DRIVE_FWD = 4'd2,
    OP_DRIVE_REV = 4'd3,
    OP_SET_POS   = 4'd4,
    OP_GET_POS   = 4'd5,
    OP_GOTO_POS  = 4'd6,
    OP_COAST     = 4'd7,
    OP_NOP       = 4'd8
  } cmd_code_t;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PWM_PERIOD     = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TIMER_PRESCALE = 4'd1;

  localparam logic [7:0]  PWM_PERIOD_RESET = 8'hFF;
  localparam logic [7:0]  SPEED_FULL       = 8'hFF;
  localparam logic [15:0] VERSION_WORD     = 16'h0200;

  // Reply kinds
  localparam logic REPLY_VERSION  = 1'b0;
  localparam logic REPLY_POSITION = 1'b1;

  typedef struct packed {
    logic [CMD_BITS-1:0]              command;
    logic [7:0]                       speed;
    logic signed [FIELD_POS_BITS-1:0] position_value;
    logic                             opto_level;
  } cmd_item_t;

  typedef struct packed {
    logic                             forward_enable;
    logic                             reverse_enable;
    logic                             pwm_enabled;
    logic [7:0]                       pwm_duty;
    logic [7:0]                       pwm_top;
    logic [1:0]                       prescale_out;
    logic signed [FIELD_POS_BITS-1:0] position_count;
    logic                             reply_valid;
    logic                             reply_kind;
    logic [15:0]                      reply_data;
  } res_item_t;

  typedef struct packed {
    logic [7:0] pwm_period;
    logic [1:0] timer_prescale;
  } cfg_t;

endpackage

/* src/dcm_ifs.sv */
// Command / sensor sample channel
interface dcm_cmd_if import dcm_pkg::*; ();
  logic                             valid;
  logic                             ready;
  logic [CMD_BITS-1:0]              command;
  logic [7:0]                       speed;
  logic signed [FIELD_POS_BITS-1:0] position_value;
  logic                             opto_level;

  modport source (output valid, command, speed, position_value, opto_level, input ready);
  modport sink (input valid, command, speed, position_value, opto_level, output ready);
endinterface

// Result channel
interface dcm_res_if import dcm_pkg::*; ();
  logic                             valid;
  logic                             ready;
  logic                             forward_enable;
  logic                             reverse_enable;
  logic                             pwm_enabled;
  logic [7:0]                       pwm_duty;
  logic [7:0]                       pwm_top;
  logic [1:0]                       prescale_out;
  logic signed [FIELD_POS_BITS-1:0] position_count;
  logic                             reply_valid;
  logic                             reply_kind;
  logic [15:0]                      reply_data;

  modport source (output valid, forward_enable, reverse_enable, pwm_enabled, pwm_duty,
                  pwm_top, prescale_out, position_count, reply_valid, reply_kind,
                  reply_data, input ready);
  modport sink (input valid, forward_enable, reverse_enable, pwm_enabled, pwm_duty,
                pwm_top, prescale_out, position_count, reply_valid, reply_kind,
                reply_data, output ready);
endinterface

// Configuration write channel
interface dcm_cfg_if import dcm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [7:0]                data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/dcm_cfg.sv */
module dcm_cfg import dcm_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  dcm_cfg_if.sink        cfg,
  output cfg_t           regs
);

  // Always take writes
  assign cfg.ready = 1'b1;

  // Update the addressed register, drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pwm_period     <= PWM_PERIOD_RESET;
      regs.timer_prescale <= 2'd0;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_PWM_PERIOD) begin
        regs.pwm_period <= cfg.data;
      end else if (cfg.index == CFG_TIMER_PRESCALE) begin
        regs.timer_prescale <= cfg.data[1:0];
      end
    end
  end

endmodule

/* src/dcm_core.sv */
module dcm_core import dcm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  cmd_item_t item,
  input  cfg_t      regs,
  output res_item_t result
);

  `include "assert_macros.svh"

  logic [POSITION_BITS-1:0] position, position_next;
  logic [POSITION_BITS-1:0] seek_target, seek_target_next;
  logic [7:0]               seek_speed, seek_speed_next;
  logic                     direction_reverse, direction_reverse_next;
  logic                     last_opto, last_opto_next;
  logic [1:0]               enables, enables_next;
  logic [7:0]               duty, duty_next;
  logic                     pwm_on, pwm_on_next;
  logic                     full_speed, full_speed_next;

  logic [POS_WIDE_BITS-1:0] pv_wide;
  logic [POS_WIDE_BITS-1:0] pos_wide;
  logic [POSITION_BITS-1:0] pv;
  logic [POSITION_BITS-1:0] pos_stepped;
  logic [7:0]               spd_sel;
  logic                     rev_sel;
  logic                     speed_load;
  logic                     rep_valid;
  logic                     rep_kind;

  // Sign extend the field to the counter width
  assign pv_wide = POS_WIDE_BITS'(item.position_value);
  assign pv      = pv_wide[POSITION_BITS-1:0];

  // Counter moved by one marker
  assign pos_stepped = direction_reverse ? position - 1'b1 : position + 1'b1;

  // Decode the item into the next state
  always_comb begin
    position_next          = position;
    seek_target_next       = seek_target;
    seek_speed_next        = seek_speed;
    direction_reverse_next = direction_reverse;
    last_opto_next         = last_opto;
    enables_next           = enables;
    duty_next              = duty;
    pwm_on_next            = pwm_on;
    full_speed_next        = full_speed;
    speed_load             = 1'b0;
    spd_sel                = item.speed;
    rev_sel                = 1'b0;
    rep_valid              = 1'b0;
    rep_kind               = REPLY_VERSION;

    case (item.command)
      OP_SENSOR: begin
        if (item.opto_level && !last_opto) begin
          position_next = pos_stepped;
          if (seek_speed != 8'd0 && pos_stepped == seek_target) begin
            seek_speed_next = 8'd0;
            enables_next    = 2'b00;
            duty_next       = 8'd0;
          end
        end
        last_opto_next = item.opto_level;
      end
      OP_ID_QUERY: begin
        rep_valid = 1'b1;
        rep_kind  = REPLY_VERSION;
      end
      OP_DRIVE_FWD: begin
        speed_load = 1'b1;
      end
      OP_DRIVE_REV: begin
        speed_load = 1'b1;
        rev_sel    = 1'b1;
      end
      OP_SET_POS: begin
        position_next = pv;
      end
      OP_GET_POS: begin
        rep_valid = 1'b1;
        rep_kind  = REPLY_POSITION;
      end
      OP_GOTO_POS: begin
        seek_target_next = pv;
        if (pv != position) begin
          seek_speed_next = item.speed;
          speed_load      = 1'b1;
          rev_sel         = $signed(position) > $signed(pv);
        end
      end
      OP_COAST: begin
        speed_load = 1'b1;
        spd_sel    = 8'd0;
      end
      default: begin
      end
    endcase

    // Apply a new speed and direction
    if (speed_load) begin
      enables_next           = (spd_sel == 8'd0) ? 2'b00 : (rev_sel ? 2'b10 : 2'b01);
      pwm_on_next            = (spd_sel != 8'd0);
      duty_next              = spd_sel;
      full_speed_next        = (spd_sel == SPEED_FULL);
      direction_reverse_next = rev_sel;
    end
  end

  // Zero extend the counter for the result
  assign pos_wide = POS_WIDE_BITS'(position_next);

  // Build the status for this item
  always_comb begin
    result.forward_enable = enables_next[0];
    result.reverse_enable = enables_next[1];
    result.pwm_enabled    = pwm_on_next;
    result.pwm_duty       = duty_next;
    result.pwm_top        = full_speed_next ? 8'd0 : regs.pwm_period;
    result.prescale_out   = regs.timer_prescale;
    result.position_count = pos_wide[FIELD_POS_BITS-1:0];
    result.reply_valid    = rep_valid;
    result.reply_kind     = rep_kind;
    if (!rep_valid) begin
      result.reply_data = '0;
    end else if (rep_kind == REPLY_POSITION) begin
      result.reply_data = pos_wide[15:0];
    end else begin
      result.reply_data = VERSION_WORD;
    end
  end

  // Commit the state when the item moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      position          <= '0;
      seek_target       <= '0;
      seek_speed        <= 8'd0;
      direction_reverse <= 1'b0;
      last_opto         <= 1'b0;
      enables           <= 2'b00;
      duty              <= 8'd0;
      pwm_on            <= 1'b0;
      full_speed        <= 1'b0;
    end else if (step) begin
      position          <= position_next;
      seek_target       <= seek_target_next;
      seek_speed        <= seek_speed_next;
      direction_reverse <= direction_reverse_next;
      last_opto         <= last_opto_next;
      enables           <= enables_next;
      duty              <= duty_next;
      pwm_on            <= pwm_on_next;
      full_speed        <= full_speed_next;
    end
  end

  `AST_CLK(a_bridge_onehot, $onehot0(enables), "both bridge enables set")
  `AST_CLK(a_pwm_off_bridge_off, !pwm_on |-> enables == 2'b00, "bridge on with pwm off")
  `AST_CLK(a_full_duty, full_speed |-> duty == SPEED_FULL || duty == 8'd0, "full speed duty")

endmodule

/* src/dc_motor_position_seek_controller.sv */
// Channel  Role     Payload
// cmd      sink     command, speed, position_value, opto_level
// res      source   bridge enables, pwm state, position_count, reply
// cfg      sink     index, data (pwm_period, timer_prescale)
//
// Items pass the input then the result register; one per cycle while res is ready.
// The state update sits between the input register and the result register.
// Reset (rst, synchronous) clears the motor state, pwm_period to 255, prescale 0.
// A stalled res holds the result register; the input register still fills,
// so cmd stalls only when both stages are occupied and res is not ready.
module dc_motor_position_seek_controller import dcm_pkg::*; (
  input logic     clk,
  input logic     rst,
  dcm_cmd_if.sink   cmd,
  dcm_res_if.source res,
  dcm_cfg_if.sink   cfg
);

  `include "assert_macros.svh"

  cfg_t      regs;
  cmd_item_t in_item;
  logic      in_valid;
  res_item_t core_result;
  res_item_t out_item;
  logic      out_valid;
  logic      advance;
  logic      out_no_reply;
  logic      reply_clear;

  dcm_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  dcm_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_item),
    .regs   (regs),
    .result (core_result)
  );

  // Move the held item into the result register when it is free
  assign advance   = in_valid && (!out_valid || res.ready);
  assign cmd.ready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_item.command        <= cmd.command;
      in_item.speed          <= cmd.speed;
      in_item.position_value <= cmd.position_value;
      in_item.opto_level     <= cmd.opto_level;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= core_result;
    end
  end

  assign res.valid          = out_valid;
  assign res.forward_enable = out_item.forward_enable;
  assign res.reverse_enable = out_item.reverse_enable;
  assign res.pwm_enabled    = out_item.pwm_enabled;
  assign res.pwm_duty       = out_item.pwm_duty;
  assign res.pwm_top        = out_item.pwm_top;
  assign res.prescale_out   = out_item.prescale_out;
  assign res.position_count = out_item.position_count;
  assign res.reply_valid    = out_item.reply_valid;
  assign res.reply_kind     = out_item.reply_kind;
  assign res.reply_data     = out_item.reply_data;

  // Reply fields stay clear on items without a reply
  assign out_no_reply = out_valid && !out_item.reply_valid;
  assign reply_clear  = out_item.reply_data == 16'd0 && out_item.reply_kind == REPLY_VERSION;

  `AST_CLK(a_in_hold, in_valid && !advance |=> in_valid, "stalled input item lost")
  `AST_CLK(a_in_fill, cmd.valid && cmd.ready |=> in_valid, "accepted item not held")
  `AST_CLK(a_no_reply_zero, out_no_reply |-> reply_clear, "reply fields set without reply")
  `AST_CLK_ALWAYS(a_rst_empty, rst |=> !in_valid && !out_valid, "pipeline busy after reset")

endmodule

/* sim/tb.sv */
module tb;
  import dcm_pkg::*;

  // Command codes past the no-op do nothing
  localparam logic [CMD_BITS-1:0] CMD_FIRST_UNUSED = CMD_BITS'(OP_NOP + 1);
  localparam logic [CMD_BITS-1:0] CMD_LAST_CODE    = '1;

  logic clk;
  logic rst;

  dcm_cmd_if cmd_ch();
  dcm_res_if res_ch();
  dcm_cfg_if cfg_ch();

  dc_motor_position_seek_controller DUT (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  // Motor state as the block should hold it
  logic signed [POSITION_BITS-1:0] pos_cnt;
  logic signed [POSITION_BITS-1:0] seek_goal;
  logic [7:0]                      seek_spd;
  logic                            dir_rev;
  logic                            prev_opto;
  logic [1:0]                      bridge_en;
  logic [7:0]                      duty_val;
  logic                            pwm_run;
  logic                            full_spd;
  logic [7:0]                      period_reg;
  logic [1:0]                      presc_reg;

  res_item_t status_q[$];
  int        items_sent;
  int        error_count;
  int        hold_cycles;
  bit        steady_flow;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up long after the slowest correct run would have ended
  initial begin
    #3000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic void reset_model();
    pos_cnt    = '0;
    seek_goal  = '0;
    seek_spd   = '0;
    dir_rev    = 1'b0;
    prev_opto  = 1'b0;
    bridge_en  = 2'b00;
    duty_val   = '0;
    pwm_run    = 1'b0;
    full_spd   = 1'b0;
    period_reg = PWM_PERIOD_RESET;
    presc_reg  = '0;
  endfunction

  // Set speed and direction; a zero speed drops both bridge enables
  function automatic void apply_drive(input logic [7:0] spd, input logic rev);
    bridge_en = (spd == '0) ? 2'b00 : (rev ? 2'b10 : 2'b01);
    pwm_run   = (spd != '0);
    duty_val  = spd;
    full_spd  = (spd == SPEED_FULL);
    dir_rev   = rev;
  endfunction

  // Advance the motor state by one item and return the status it shows
  function automatic res_item_t motor_step(input cmd_item_t it);
    res_item_t                       r;
    logic signed [POSITION_BITS-1:0] pv;
    pv = it.position_value;
    r  = '0;
    case (it.command)
      OP_SENSOR: begin
        if (it.opto_level && !prev_opto) begin
          pos_cnt = dir_rev ? pos_cnt - 1'b1 : pos_cnt + 1'b1;
          if (seek_spd != '0 && pos_cnt == seek_goal) begin
            seek_spd  = '0;
            bridge_en = 2'b00;
            duty_val  = '0;
          end
        end
        prev_opto = it.opto_level;
      end
      OP_ID_QUERY: begin
        r.reply_valid = 1'b1;
        r.reply_kind  = REPLY_VERSION;
        r.reply_data  = VERSION_WORD;
      end
      OP_DRIVE_FWD: apply_drive(it.speed, 1'b0);
      OP_DRIVE_REV: apply_drive(it.speed, 1'b1);
      OP_SET_POS: pos_cnt = pv;
      OP_GET_POS: begin
        r.reply_valid = 1'b1;
        r.reply_kind  = REPLY_POSITION;
        r.reply_data  = pos_cnt[15:0];
      end
      OP_GOTO_POS: begin
        seek_goal = pv;
        if (seek_goal != pos_cnt) begin
          seek_spd = it.speed;
          apply_drive(it.speed, pos_cnt > seek_goal);
        end
      end
      OP_COAST: apply_drive('0, 1'b0);
      default: ;
    endcase
    r.forward_enable = bridge_en[0];
    r.reverse_enable = bridge_en[1];
    r.pwm_enabled    = pwm_run;
    r.pwm_duty       = duty_val;
    r.pwm_top        = full_spd ? '0 : period_reg;
    r.prescale_out   = presc_reg;
    r.position_count = pos_cnt[FIELD_POS_BITS-1:0];
    return r;
  endfunction

  function automatic cmd_item_t make_item(input logic [CMD_BITS-1:0] code,
                                          input logic [7:0] spd,
                                          input logic signed [FIELD_POS_BITS-1:0] pv,
                                          input logic opto);
    cmd_item_t it;
    it.command        = code;
    it.speed          = spd;
    it.position_value = pv;
    it.opto_level     = opto;
    return it;
  endfunction

  function automatic logic [7:0] random_speed();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 25) return SPEED_FULL;
    return 8'($urandom_range(254, 1));
  endfunction

  // Half the time anywhere, half the time right at the wrap points
  function automatic logic signed [FIELD_POS_BITS-1:0] random_position();
    case ($urandom_range(3))
      0:       return 16'sh7FFF - 16'($urandom_range(3));
      1:       return 16'sh8000 + 16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cmd_item_t random_item();
    return make_item(4'($urandom_range(CMD_LAST_CODE, 0)), 8'($urandom),
                     16'($urandom), 1'($urandom));
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_error($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Offer one item, idling at random first; return at the falling edge after acceptance
  task automatic send_item(input cmd_item_t it);
    while (!steady_flow && $urandom_range(99) < 17) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid          <= 1'b1;
    cmd_ch.command        <= it.command;
    cmd_ch.speed          <= it.speed;
    cmd_ch.position_value <= it.position_value;
    cmd_ch.opto_level     <= it.opto_level;
    do begin
      @(posedge clk);
    end while (!cmd_ch.ready);
    status_q.push_back(motor_step(it));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_pulse();
    send_item(make_item(OP_SENSOR, 8'($urandom), 16'($urandom), 1'b1));
    send_item(make_item(OP_SENSOR, 8'($urandom), 16'($urandom), 1'b0));
  endtask

  // Drain, let the pipeline empty, then write both registers
  task automatic apply_config(input logic [7:0] period, input logic [1:0] presc);
    cmd_ch.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_PWM_PERIOD;
    cfg_ch.data  <= period;
    do begin
      @(posedge clk);
    end while (!cfg_ch.ready);
    period_reg = period;
    @(negedge clk);
    cfg_ch.index <= CFG_TIMER_PRESCALE;
    cfg_ch.data  <= {6'b0, presc};
    do begin
      @(posedge clk);
    end while (!cfg_ch.ready);
    presc_reg = presc;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_item(make_item(OP_ID_QUERY, '0, '0, 1'b0));
    send_item(make_item(OP_GET_POS, '0, '0, 1'b0));
    send_item(make_item(OP_NOP, 8'hFF, 16'sh7FFF, 1'b1));
  endtask

  task automatic test_drive_commands();
    send_item(make_item(OP_DRIVE_FWD, 8'd1, '0, 1'b0));
    send_item(make_item(OP_DRIVE_FWD, SPEED_FULL, '0, 1'b0));
    send_item(make_item(OP_DRIVE_REV, 8'd254, '0, 1'b0));
    send_item(make_item(OP_DRIVE_REV, '0, '0, 1'b0));
    send_item(make_item(OP_COAST, 8'd99, '0, 1'b0));
    send_item(make_item(CMD_FIRST_UNUSED, 8'd50, 16'sh1234, 1'b1));
    send_item(make_item(CMD_LAST_CODE, 8'hFF, 16'sh8000, 1'b1));
  endtask

  // Wrap the counter both ways; steady and falling levels hold it
  task automatic test_position_counter();
    send_item(make_item(OP_SET_POS, '0, 16'sh7FFF, 1'b0));
    send_item(make_item(OP_DRIVE_FWD, 8'd5, '0, 1'b0));
    send_item(make_item(OP_SENSOR, '0, '0, 1'b1));
    send_item(make_item(OP_SENSOR, '0, '0, 1'b1));
    send_item(make_item(OP_SENSOR, '0, '0, 1'b0));
    send_item(make_item(OP_DRIVE_REV, 8'd5, '0, 1'b0));
    send_item(make_item(OP_SENSOR, '0, '0, 1'b1));
    send_item(make_item(OP_SENSOR, '0, '0, 1'b0));
    send_item(make_item(OP_GET_POS, '0, '0, 1'b0));
  endtask

  task automatic test_seek_mode();
    // Seek to where the counter already is, then with zero speed
    send_item(make_item(OP_GOTO_POS, 8'd77, pos_cnt, 1'b0));
    send_item(make_item(OP_GOTO_POS, '0, pos_cnt + 16'sd5, 1'b0));
    // Full-speed seek two markers ahead wraps past 0x7FFF, so it runs in reverse
    send_item(make_item(OP_GOTO_POS, SPEED_FULL, pos_cnt + 16'sd2, 1'b0));
    send_pulse();
    send_item(make_item(OP_SENSOR, '0, '0, 1'b1));
    // Reverse seek of one step
    send_item(make_item(OP_GOTO_POS, 8'd40, pos_cnt - 16'sd1, 1'b1));
    send_item(make_item(OP_SENSOR, '0, '0, 1'b0));
    send_item(make_item(OP_SENSOR, '0, '0, 1'b1));
  endtask

  // Seek one to twelve steps away and feed sensor pulses, up to two past the stop
  task automatic run_seek_sequence();
    int                               steps;
    int                               extra;
    logic signed [FIELD_POS_BITS-1:0] goal;
    if ($urandom_range(3) == 0)
      send_item(make_item(OP_SET_POS, 8'($urandom), random_position(), 1'($urandom)));
    steps = $urandom_range(12, 1);
    extra = $urandom_range(2);
    goal  = ($urandom_range(1) == 1) ? FIELD_POS_BITS'(pos_cnt + steps)
                                     : FIELD_POS_BITS'(pos_cnt - steps);
    send_item(make_item(OP_SENSOR, 8'($urandom), 16'($urandom), 1'b0));
    send_item(make_item(OP_GOTO_POS, random_speed(), goal, 1'($urandom)));
    for (int i = 0; i < steps + extra; i++) begin
      send_pulse();
      if ($urandom_range(9) == 0)
        send_item(make_item(OP_GET_POS, 8'($urandom), 16'($urandom), 1'($urandom)));
    end
  endtask

  task automatic run_drive_sequence();
    logic [CMD_BITS-1:0] code;
    code = ($urandom_range(1) == 1) ? OP_DRIVE_REV : OP_DRIVE_FWD;
    send_item(make_item(code, random_speed(), 16'($urandom), 1'($urandom)));
    repeat ($urandom_range(6, 1)) send_pulse();
    if ($urandom_range(1) == 1)
      send_item(make_item(OP_GET_POS, 8'($urandom), 16'($urandom), 1'($urandom)));
  endtask

  task automatic test_random_traffic(input int n_items);
    int stop_at;
    int pick;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 55) run_seek_sequence();
      else if (pick < 75) run_drive_sequence();
      else send_item(random_item());
    end
  endtask

  // Hold off the result side while items keep coming, so the input stalls
  task automatic test_backpressure();
    steady_flow = 1'b1;
    hold_cycles = 60;
    repeat (16) send_item(random_item());
    steady_flow = 1'b0;
  endtask

  // Result side readiness: counted hold-off first, else random idling unless steady_flow
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      res_ch.ready <= 1'b0;
      hold_cycles--;
    end else begin
      res_ch.ready <= steady_flow || ($urandom_range(99) >= 17);
    end
  end

  // Compare each result transaction with the oldest expected status
  always @(posedge clk) begin
    res_item_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (status_q.size() == 0) begin
        report_error("result transaction with no expected status");
      end else begin
        want = status_q.pop_front();
        check_field("forward_enable", 16'(res_ch.forward_enable), 16'(want.forward_enable));
        check_field("reverse_enable", 16'(res_ch.reverse_enable), 16'(want.reverse_enable));
        check_field("pwm_enabled", 16'(res_ch.pwm_enabled), 16'(want.pwm_enabled));
        check_field("pwm_duty", 16'(res_ch.pwm_duty), 16'(want.pwm_duty));
        check_field("pwm_top", 16'(res_ch.pwm_top), 16'(want.pwm_top));
        check_field("prescale_out", 16'(res_ch.prescale_out), 16'(want.prescale_out));
        check_field("position_count", 16'(res_ch.position_count),
                    16'(want.position_count));
        check_field("reply_valid", 16'(res_ch.reply_valid), 16'(want.reply_valid));
        check_field("reply_kind", 16'(res_ch.reply_kind), 16'(want.reply_kind));
        check_field("reply_data", res_ch.reply_data, want.reply_data);
      end
    end
  end

  initial begin
    clk                   = 1'b0;
    rst                   = 1'b1;
    cmd_ch.valid          = 1'b0;
    cmd_ch.command        = OP_NOP;
    cmd_ch.speed          = '0;
    cmd_ch.position_value = '0;
    cmd_ch.opto_level     = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = CFG_PWM_PERIOD;
    cfg_ch.data           = '0;
    res_ch.ready          = 1'b0;
    items_sent            = 0;
    error_count           = 0;
    hold_cycles           = 0;
    steady_flow           = 1'b0;
    reset_model();
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    apply_config('0, 2'd3);
    test_drive_commands();
    test_position_counter();
    test_seek_mode();

    apply_config(PWM_PERIOD_RESET, 2'd0);
    test_random_traffic(140);
    apply_config(8'd1, 2'd1);
    test_backpressure();
    test_random_traffic(130);
    apply_config(8'($urandom), 2'($urandom));
    steady_flow = 1'b1;
    test_random_traffic(120);
    steady_flow = 1'b0;
    apply_config(8'd128, 2'd2);
    test_random_traffic(140);
    apply_config(8'($urandom), 2'($urandom));
    test_random_traffic(140);

    // Drain outstanding results, then watch for strays
    cmd_ch.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
